// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL.
// PT_ASSERT checks a property on every rising clock edge outside reset.
// PT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: property failed");
`define PT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define PT_ASSERT(lbl, clk, rstn, prop)
`define PT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== src/ptr_pkg.sv =====
`default_nettype none
package ptr_pkg;

	localparam int NUM_COORDS = 4;
	localparam int OUT_IDX_W  = 3;

	// Item kinds on the input stream
	typedef enum logic [1:0] {
		OP_LOAD_TERM = 2'd0,
		OP_LOAD_OUT  = 2'd1,
		OP_EVAL      = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_X_POS_OFFSET      = 3'd0,
		REG_X_ANGLE_OFFSET    = 3'd1,
		REG_Y_POS_OFFSET      = 3'd2,
		REG_Y_ANGLE_OFFSET    = 3'd3,
		REG_X_POS_INV_RANGE   = 3'd4,
		REG_X_ANGLE_INV_RANGE = 3'd5,
		REG_Y_POS_INV_RANGE   = 3'd6,
		REG_Y_ANGLE_INV_RANGE = 3'd7
	} reg_idx_t;

	localparam logic [31:0] RST_X_POS_OFFSET      = 32'd267715;
	localparam logic [31:0] RST_X_ANGLE_OFFSET    = 32'd1110;
	localparam logic [31:0] RST_Y_POS_OFFSET      = 32'd577634;
	localparam logic [31:0] RST_Y_ANGLE_OFFSET    = 32'd1342;
	localparam logic [31:0] RST_X_POS_INV_RANGE   = 32'd641087;
	localparam logic [31:0] RST_X_ANGLE_INV_RANGE = 32'd142179797;
	localparam logic [31:0] RST_Y_POS_INV_RANGE   = 32'd3546980;
	localparam logic [31:0] RST_Y_ANGLE_INV_RANGE = 32'd1095834062;

	localparam logic [31:0] ONE_Q8_24 = 32'h0100_0000;
	localparam logic [31:0] ONE_Q4_28 = 32'h1000_0000;

	// Multiply flavors: shift and saturation width
	typedef enum logic [1:0] {
		MK_SCALE = 2'd0,  // >>12, 32 bits
		MK_MONO  = 2'd1,  // >>28, 32 bits
		MK_TERM  = 2'd2,  // >>28, 48 bits
		MK_OUT   = 2'd3   // >>20, 48 bits
	} mul_kind_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_LO,
		MS_HI,
		MS_ROUND,
		MS_CLAMP
	} mul_state_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCALE,
		ST_SCALE_WAIT,
		ST_OUT_START,
		ST_FETCH,
		ST_TERM,
		ST_MONO,
		ST_MONO_WAIT,
		ST_COEF,
		ST_COEF_WAIT,
		ST_APPLY,
		ST_APPLY_WAIT,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		op_t                            opcode;
		logic [2:0]                     output_select;
		logic [7:0]                     term_index;
		logic [47:0]                    coefficient;
		logic [11:0]                    exponent_set;
		logic [31:0]                    out_scale;
		logic [47:0]                    out_offset;
		logic [NUM_COORDS-1:0][31:0]    coord;
	} item_t;

	typedef struct packed {
		logic [NUM_COORDS-1:0][31:0] offset;
		logic [NUM_COORDS-1:0][31:0] inv_range;
	} cfg_t;

	typedef struct packed {
		logic        start;
		mul_kind_t   kind;
		logic [48:0] a;  // signed
		logic [32:0] b;  // signed
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] value;  // signed, sign-extended for 32-bit kinds
		logic        sat;
	} mul_rsp_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] index;
		logic [47:0]          value;
		logic                 sat;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic        sat;
		logic [47:0] val;
	} sat48_t;

	// Signed 48-bit add, clamped to the 48-bit range
	function automatic sat48_t add_sat48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		sat48_t r;
		s = {a[47], a} + {b[47], b};
		r.sat = (s[48] != s[47]);
		if (r.sat) begin
			r.val = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			r.val = s[47:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/ptr_mul.sv =====
`default_nettype none
`include "assert_macros.svh"
module ptr_mul
	import ptr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);

	localparam logic [79:0] LIM32 = 80'h8000_0000;
	localparam logic [79:0] LIM48 = 80'h8000_0000_0000;

	mul_state_t state_q, state_next;
	mul_kind_t  kind_q;
	logic [47:0] amag_q;
	logic [31:0] bmag_q;
	logic        neg_q;
	logic [79:0] prod_q;
	logic [79:0] q_q;

	logic [48:0] a_neg;
	logic [32:0] b_neg;
	logic [79:0] shifted;
	logic        rem_nz;
	logic [79:0] lim;
	logic [79:0] mag_c;
	logic [23:0] a_half;
	logic [55:0] part;

	assign a_neg = -req.a;
	assign b_neg = -req.b;

	// One 24 x 32 partial product, low half first, then high half
	assign a_half = (state_q == MS_HI) ? amag_q[47:24] : amag_q[23:0];
	assign part   = {32'd0, a_half} * {24'd0, bmag_q};

	// Sequence: latch, low half, high half, round, clamp
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			MS_IDLE:  if (req.start) state_next = MS_LO;
			MS_LO:    state_next = MS_HI;
			MS_HI:    state_next = MS_ROUND;
			MS_ROUND: state_next = MS_CLAMP;
			MS_CLAMP: state_next = MS_IDLE;
			default:  state_next = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Pick the shift for this flavor
	always_comb begin
		unique case (kind_q)
			MK_SCALE: begin
				shifted = prod_q >> 12;
				rem_nz  = |prod_q[11:0];
			end
			MK_OUT: begin
				shifted = prod_q >> 20;
				rem_nz  = |prod_q[19:0];
			end
			default: begin
				shifted = prod_q >> 28;
				rem_nz  = |prod_q[27:0];
			end
		endcase
	end

	// Magnitude datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			MS_IDLE: begin
				if (req.start) begin
					amag_q <= req.a[48] ? a_neg[47:0] : req.a[47:0];
					bmag_q <= req.b[32] ? b_neg[31:0] : req.b[31:0];
					neg_q  <= req.a[48] ^ req.b[32];
					kind_q <= req.kind;
				end
			end
			MS_LO:    prod_q <= {24'd0, part};
			MS_HI:    prod_q <= prod_q + {part, 24'd0};
			MS_ROUND: q_q <= shifted + 80'(neg_q && rem_nz);
			MS_CLAMP: ;
			default: ;
		endcase
	end

	// Clamp to the target width and restore the sign
	always_comb begin
		lim = (kind_q == MK_SCALE || kind_q == MK_MONO) ? LIM32 : LIM48;
		rsp.done = (state_q == MS_CLAMP);
		rsp.sat  = 1'b0;
		mag_c    = q_q;
		if (neg_q) begin
			if (q_q > lim) begin
				rsp.sat = 1'b1;
				mag_c   = lim;
			end
			rsp.value = 48'(-mag_c);
		end else begin
			if (q_q > lim - 80'd1) begin
				rsp.sat = 1'b1;
				mag_c   = lim - 80'd1;
			end
			rsp.value = mag_c[47:0];
		end
	end

	`PT_NEVER(a_start_busy, clk, arst_n, req.start && (state_q != MS_IDLE))
	`PT_ASSERT(a_round_done, clk, arst_n, (state_q == MS_ROUND) |=> rsp.done)
	`PT_ASSERT(a_pos_sign, clk, arst_n, (rsp.done && !neg_q) |-> !rsp.value[47])

endmodule
`default_nettype wire

// ===== src/ptr_seq.sv =====
`default_nettype none
module ptr_seq
	import ptr_pkg::*;
#(
	parameter int MAX_TERMS    = 256,
	parameter int NUM_OUTPUTS  = 6,
	parameter int MAX_EXPONENT = 7
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	input  wire item_t    item,
	output logic          item_ready,
	input  wire cfg_t     cfg,
	output mul_req_t      mul_req,
	input  wire mul_rsp_t mul_rsp,
	output logic          res_valid,
	output result_t       res,
	input  wire logic     res_take
);

	localparam int DEPTH = NUM_OUTPUTS * MAX_TERMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = $clog2(MAX_TERMS);
	localparam int OW    = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

	seq_state_t state_q, state_next;

	logic [AW-1:0] clr_addr_q;
	logic [1:0]    v_q;
	logic [TW-1:0] t_q;
	logic [OW-1:0] out_q;
	logic [2:0]    ecount_q;

	logic [NUM_COORDS-1:0][31:0] coord_q;
	logic [NUM_COORDS-1:0][31:0] sc_q;
	logic        ssat_q;
	logic        sat_q;
	logic [47:0] coef_q;
	logic [11:0] expo_q;
	logic [31:0] mono_q;
	logic [47:0] acc_q;
	logic [47:0] val_q;

	logic [31:0] scale_q  [NUM_OUTPUTS];
	logic [47:0] offset_q [NUM_OUTPUTS];

	logic [59:0]   term_mem [DEPTH];
	logic [59:0]   rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [59:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;

	logic accept;
	logic last_term;
	logic last_out;
	logic rd_zero;
	logic term_ok;
	logic out_ok;
	logic [48:0] diff;
	sat48_t add_acc;
	sat48_t add_off;

	function automatic logic [2:0] clamp_exp(input logic [2:0] e);
		return (e > 3'(MAX_EXPONENT)) ? 3'(MAX_EXPONENT) : e;
	endfunction

	assign accept    = item_valid && item_ready;
	assign last_term = (t_q == TW'(MAX_TERMS - 1));
	assign last_out  = (out_q == OW'(NUM_OUTPUTS - 1));
	assign rd_zero   = (rd_q[47:0] == 48'd0);
	assign term_ok   = (32'(item.output_select) < NUM_OUTPUTS) &&
		(32'(item.term_index) < MAX_TERMS);
	assign out_ok    = (32'(item.output_select) < NUM_OUTPUTS);
	assign diff      = {{17{coord_q[v_q][31]}}, coord_q[v_q]} -
		{{17{cfg.offset[v_q][31]}}, cfg.offset[v_q]};
	assign add_acc   = add_sat48(acc_q, mul_rsp.value);
	assign add_off   = add_sat48(mul_rsp.value, offset_q[out_q]);
	assign mem_raddr = AW'(out_q) * AW'(MAX_TERMS) + AW'(t_q);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_CLEAR:      if (clr_addr_q == AW'(DEPTH - 1)) state_next = ST_IDLE;
			ST_IDLE:       if (accept && item.opcode == OP_EVAL) state_next = ST_SCALE;
			ST_SCALE:      state_next = ST_SCALE_WAIT;
			ST_SCALE_WAIT: begin
				if (mul_rsp.done) state_next = (v_q == 2'd3) ? ST_OUT_START : ST_SCALE;
			end
			ST_OUT_START:  state_next = ST_FETCH;
			ST_FETCH:      state_next = ST_TERM;
			ST_TERM: begin
				if (!rd_zero) state_next = ST_MONO;
				else state_next = last_term ? ST_APPLY : ST_FETCH;
			end
			ST_MONO: begin
				if (ecount_q != 3'd0) state_next = ST_MONO_WAIT;
				else if (v_q == 2'd3) state_next = ST_COEF;
			end
			ST_MONO_WAIT:  if (mul_rsp.done) state_next = ST_MONO;
			ST_COEF:       state_next = ST_COEF_WAIT;
			ST_COEF_WAIT: begin
				if (mul_rsp.done) state_next = last_term ? ST_APPLY : ST_FETCH;
			end
			ST_APPLY:      state_next = ST_APPLY_WAIT;
			ST_APPLY_WAIT: if (mul_rsp.done) state_next = ST_EMIT;
			ST_EMIT:       if (res_take) state_next = last_out ? ST_IDLE : ST_OUT_START;
			default:       state_next = ST_IDLE;
		endcase
	end

	// Outputs: handshake, multiplier request, term store write
	always_comb begin
		item_ready = (state_q == ST_IDLE);
		res_valid  = (state_q == ST_EMIT);
		res.index  = OUT_IDX_W'(out_q);
		res.value  = val_q;
		res.sat    = sat_q;
		res.last   = last_out;

		mul_req.start = 1'b0;
		mul_req.kind  = MK_SCALE;
		mul_req.a     = diff;
		mul_req.b     = {1'b0, cfg.inv_range[v_q]};

		mem_we    = 1'b0;
		mem_waddr = AW'(item.output_select) * AW'(MAX_TERMS) + AW'(item.term_index);
		mem_wdata = {item.exponent_set, item.coefficient};

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = 60'd0;
			end
			ST_IDLE: mem_we = accept && item.opcode == OP_LOAD_TERM && term_ok;
			ST_SCALE: mul_req.start = 1'b1;
			ST_MONO: begin
				mul_req.start = (ecount_q != 3'd0);
				mul_req.kind  = MK_MONO;
				mul_req.a     = {{17{mono_q[31]}}, mono_q};
				mul_req.b     = {sc_q[v_q][31], sc_q[v_q]};
			end
			ST_COEF: begin
				mul_req.start = 1'b1;
				mul_req.kind  = MK_TERM;
				mul_req.a     = {coef_q[47], coef_q};
				mul_req.b     = {mono_q[31], mono_q};
			end
			ST_APPLY: begin
				mul_req.start = 1'b1;
				mul_req.kind  = MK_OUT;
				mul_req.a     = {acc_q[47], acc_q};
				mul_req.b     = {1'b0, scale_q[out_q]};
			end
			default: ;
		endcase
	end

	// Control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			v_q        <= '0;
			t_q        <= '0;
			out_q      <= '0;
			ecount_q   <= '0;
		end else begin
			state_q <= state_next;
			unique case (state_q)
				ST_CLEAR: clr_addr_q <= clr_addr_q + AW'(1);
				ST_IDLE: begin
					if (accept) begin
						v_q   <= '0;
						out_q <= '0;
					end
				end
				ST_SCALE_WAIT: if (mul_rsp.done) v_q <= v_q + 2'd1;
				ST_OUT_START: t_q <= '0;
				ST_TERM: begin
					if (rd_zero) begin
						t_q <= t_q + TW'(1);
					end else begin
						v_q      <= '0;
						ecount_q <= clamp_exp(rd_q[50:48]);
					end
				end
				ST_MONO: begin
					if (ecount_q == 3'd0 && v_q != 2'd3) begin
						v_q      <= v_q + 2'd1;
						ecount_q <= clamp_exp(expo_q[5:3]);
					end
				end
				ST_MONO_WAIT: if (mul_rsp.done) ecount_q <= ecount_q - 3'd1;
				ST_COEF_WAIT: if (mul_rsp.done) t_q <= t_q + TW'(1);
				ST_EMIT: if (res_take) out_q <= out_q + OW'(1);
				default: ;
			endcase
		end
	end

	// Output scale and offset stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OUTPUTS; i++) begin
				scale_q[i]  <= ONE_Q8_24;
				offset_q[i] <= '0;
			end
		end else if (accept && item.opcode == OP_LOAD_OUT && out_ok) begin
			scale_q[item.output_select[OW-1:0]]  <= item.out_scale;
			offset_q[item.output_select[OW-1:0]] <= item.out_offset;
		end
	end

	// Evaluation datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					coord_q <= item.coord;
					ssat_q  <= 1'b0;
				end
			end
			ST_SCALE_WAIT: begin
				if (mul_rsp.done) begin
					sc_q[v_q] <= mul_rsp.value[31:0];
					ssat_q    <= ssat_q | mul_rsp.sat;
				end
			end
			ST_OUT_START: begin
				acc_q <= '0;
				sat_q <= ssat_q;
			end
			ST_TERM: begin
				coef_q <= rd_q[47:0];
				expo_q <= rd_q[59:48];
				mono_q <= ONE_Q4_28;
			end
			ST_MONO: if (ecount_q == 3'd0) expo_q <= expo_q >> 3;
			ST_MONO_WAIT: begin
				if (mul_rsp.done) begin
					mono_q <= mul_rsp.value[31:0];
					sat_q  <= sat_q | mul_rsp.sat;
				end
			end
			ST_COEF_WAIT: begin
				if (mul_rsp.done) begin
					acc_q <= add_acc.val;
					sat_q <= sat_q | mul_rsp.sat | add_acc.sat;
				end
			end
			ST_APPLY_WAIT: begin
				if (mul_rsp.done) begin
					val_q <= add_off.val;
					sat_q <= sat_q | mul_rsp.sat | add_off.sat;
				end
			end
			default: ;
		endcase
	end

	// Term store
	always_ff @(posedge clk) begin
		if (mem_we) term_mem[mem_waddr] <= mem_wdata;
		rd_q <= term_mem[mem_raddr];
	end

endmodule
`default_nettype wire

// ===== src/polynomial_track_reconstruction_top.sv =====
`default_nettype none
// Polynomial track reconstruction: turns four focal-plane coordinates into
// NUM_OUTPUTS reconstructed quantities. Input kind (tuser) 0 loads one term,
// 1 loads an output's scale and offset, 2 evaluates and returns NUM_OUTPUTS
// results, tlast on the final one. Loads keep the block ready. After reset
// the term store's NUM_OUTPUTS*MAX_TERMS entries (1536 by default) are
// cleared, during which no item is taken; register writes are taken at any
// time. All products are formed one at a time on one shared multiplier, in
// latch, low half, high half, round and clamp steps. An evaluation scales the
// coordinates, sums each output's nonzero terms, applies scale and offset and
// waits on the consumer for each result; one item is worked on at a time.
module polynomial_track_reconstruction_top
	import ptr_pkg::*;
#(
	parameter int MAX_TERMS    = 256,
	parameter int NUM_OUTPUTS  = 6,
	parameter int MAX_EXPONENT = 7
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// output_select, term_index, coefficient, exponent_set, out_scale,
	// out_offset, x_pos, x_angle, y_pos, y_angle, one pad bit
	input  wire logic [279:0] s_axis_tdata,
	// opcode
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// value
	output logic [47:0]       m_axis_tdata,
	// output_index, saturated
	output logic [3:0]        m_axis_tuser,
	output logic              m_axis_tlast
);

	cfg_t     cfg_q;
	item_t    item;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	result_t  res;
	logic     res_valid;
	logic     res_take;
	result_t  out_q;
	logic     out_valid_q;

	// Unpack the request
	always_comb begin
		item.opcode        = op_t'(s_axis_tuser);
		item.output_select = s_axis_tdata[2:0];
		item.term_index    = s_axis_tdata[10:3];
		item.coefficient   = s_axis_tdata[58:11];
		item.exponent_set  = s_axis_tdata[70:59];
		item.out_scale     = s_axis_tdata[102:71];
		item.out_offset    = s_axis_tdata[150:103];
		item.coord[0]      = s_axis_tdata[182:151];
		item.coord[1]      = s_axis_tdata[214:183];
		item.coord[2]      = s_axis_tdata[246:215];
		item.coord[3]      = s_axis_tdata[278:247];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset[0]    <= RST_X_POS_OFFSET;
			cfg_q.offset[1]    <= RST_X_ANGLE_OFFSET;
			cfg_q.offset[2]    <= RST_Y_POS_OFFSET;
			cfg_q.offset[3]    <= RST_Y_ANGLE_OFFSET;
			cfg_q.inv_range[0] <= RST_X_POS_INV_RANGE;
			cfg_q.inv_range[1] <= RST_X_ANGLE_INV_RANGE;
			cfg_q.inv_range[2] <= RST_Y_POS_INV_RANGE;
			cfg_q.inv_range[3] <= RST_Y_ANGLE_INV_RANGE;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_X_POS_OFFSET:      cfg_q.offset[0]    <= cfg_wdata;
				REG_X_ANGLE_OFFSET:    cfg_q.offset[1]    <= cfg_wdata;
				REG_Y_POS_OFFSET:      cfg_q.offset[2]    <= cfg_wdata;
				REG_Y_ANGLE_OFFSET:    cfg_q.offset[3]    <= cfg_wdata;
				REG_X_POS_INV_RANGE:   cfg_q.inv_range[0] <= cfg_wdata;
				REG_X_ANGLE_INV_RANGE: cfg_q.inv_range[1] <= cfg_wdata;
				REG_Y_POS_INV_RANGE:   cfg_q.inv_range[2] <= cfg_wdata;
				REG_Y_ANGLE_INV_RANGE: cfg_q.inv_range[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ptr_seq #(
		.MAX_TERMS    (MAX_TERMS),
		.NUM_OUTPUTS  (NUM_OUTPUTS),
		.MAX_EXPONENT (MAX_EXPONENT)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.item       (item),
		.item_ready (s_axis_tready),
		.cfg        (cfg_q),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	ptr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Output register: take a result whenever the slot is free or draining
	assign res_take = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.value;
	assign m_axis_tuser  = {out_q.sat, out_q.index};
	assign m_axis_tlast  = out_q.last;

endmodule
`default_nettype wire
